/* src/bdkr_pkg.sv */
// ----------------------------------------------------------------------------
// bdkr_pkg
// Shared types and constants for the button debounce / keycode report block.
// ----------------------------------------------------------------------------
package bdkr_pkg;

	localparam int PORT_W    = 16;
	localparam int TIME_W    = 32;
	localparam int DEB_W     = 16;
	localparam int KEY_W     = 8;
	localparam int SLOTS     = 6;
	localparam int CNT_W     = 3;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;
	localparam int ENTRY_W   = 4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_KEYS    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WAKEUP  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIN_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_HIGH = 2'd3;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 16'd5;
	localparam logic [PORT_W-1:0] PIN_ENABLE_RST = 16'hF7FB;
	localparam logic [ENTRY_W-1:0] LAST_ENTRY    = 4'd15;

	typedef struct packed {
		logic [PORT_W-1:0] raw_port;
		logic [TIME_W-1:0] now_ms;
		logic              host_ready;
		logic              bus_suspended;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [KEY_W-1:0]  key_slot0;
		logic [KEY_W-1:0]  key_slot1;
		logic [KEY_W-1:0]  key_slot2;
		logic [KEY_W-1:0]  key_slot3;
		logic [KEY_W-1:0]  key_slot4;
		logic [KEY_W-1:0]  key_slot5;
		logic [CNT_W-1:0]  key_count;
	} out_item_t;

endpackage

/* src/bdkr_elapsed_cmp.sv */
// ----------------------------------------------------------------------------
// bdkr_elapsed_cmp
// Shared elapsed-time unit: wrapping 32-bit subtract, compare against limit.
// ----------------------------------------------------------------------------
module bdkr_elapsed_cmp
	import bdkr_pkg::*;
(
	input  logic [TIME_W-1:0] now_ms,
	input  logic [TIME_W-1:0] last_ms,
	input  logic [DEB_W-1:0]  limit_ms,
	output logic              expired
);

	logic [TIME_W-1:0] elapsed;

	assign elapsed = now_ms - last_ms;
	assign expired = elapsed > {{(TIME_W-DEB_W){1'b0}}, limit_ms};

endmodule

/* src/button_debounce_keycode_report_core.sv */
// ----------------------------------------------------------------------------
// button_debounce_keycode_report_core
// Polls an active-low button port, debounces each pin against a per-pin
// toggle timestamp and emits keyboard, release or wakeup results.
// ----------------------------------------------------------------------------
//  channel | signals                               | transfer when
//  --------+---------------------------------------+------------------------
//  in      | in_valid, in_ready, in_data           | in_valid & in_ready
//  out     | out_valid, out_ready, out_data        | out_valid & out_ready
//  cfg     | cfg_valid, cfg_ready, cfg_index/_data | cfg_valid & cfg_ready
//
//  Each poll compares the debounced word with the pins. When they differ,
//  the sequencer walks every pin through the shared elapsed-time comparator,
//  else it skips that walk; a key report then walks every pin again for
//  keycode packing. Polls without a key report skip the packing walk.
//  in_ready is high only while the sequencer idles; a finished result waits
//  in the output register, and the next poll stalls only at its own end.
//  Reset clears the debounced word, all timestamps and the reported flag.
// ----------------------------------------------------------------------------
module button_debounce_keycode_report_core
	import bdkr_pkg::*;
#(
	parameter int NUM_PINS = 16,
	parameter int MAX_KEYS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
	localparam logic [PORT_W-1:0] PIN_SPACE = PORT_W'((32'd1 << NUM_PINS) - 32'd1);
	localparam logic [PW-1:0] LAST_PIN = PW'(NUM_PINS - 1);
	localparam logic [CNT_W-1:0] KEY_LIMIT = CNT_W'(MAX_KEYS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CMP    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_PACK   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]              state_q;
	logic [DEB_W-1:0]        debounce_q;
	logic [PORT_W-1:0]       pin_enable_q;
	logic [2*CFG_W-1:0]      keymap_q;
	logic [PORT_W-1:0]       stable_q;
	logic [TIME_W-1:0]       last_toggle_q [NUM_PINS];
	logic                    keys_reported_q;
	logic [PORT_W-1:0]       pressed_q;
	logic [TIME_W-1:0]       now_q;
	logic                    host_ready_q;
	logic                    suspended_q;
	logic                    changed_q;
	logic [PW-1:0]           pin_q;
	logic [CNT_W-1:0]        n_q;
	logic [KIND_W-1:0]       kind_q;
	logic [KEY_W-1:0]        slot_q [SLOTS];
	logic                    out_valid_q;
	out_item_t               out_q;

	logic [PORT_W-1:0]  enabled;
	logic [PORT_W-1:0]  pin_bit;
	logic               expired;
	logic [ENTRY_W-1:0] entry;
	logic [KEY_W-1:0]   keycode;
	logic               out_free;

	assign enabled   = pin_enable_q & PIN_SPACE;
	assign pin_bit   = PORT_W'(1) << pin_q;
	assign entry     = LAST_ENTRY - ENTRY_W'(pin_q);
	assign keycode   = keymap_q[entry*KEY_W +: KEY_W];
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bdkr_elapsed_cmp u_cmp (
		.now_ms   (now_q),
		.last_ms  (last_toggle_q[pin_q]),
		.limit_ms (debounce_q),
		.expired  (expired)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			pin_enable_q <= PIN_ENABLE_RST;
			keymap_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:    debounce_q <= cfg_data[DEB_W-1:0];
				REG_PIN_ENABLE:  pin_enable_q <= cfg_data[PORT_W-1:0];
				REG_KEYMAP_LOW:  keymap_q[CFG_W-1:0] <= cfg_data;
				REG_KEYMAP_HIGH: keymap_q[2*CFG_W-1:CFG_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-pin toggle timestamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PINS; i++) last_toggle_q[i] <= '0;
		end else if (state_q == ST_SCAN && (enabled & pin_bit) != '0 &&
				((stable_q ^ pressed_q) & pin_bit) != '0 && expired) begin
			last_toggle_q[pin_q] <= now_q;
		end
	end

	// poll capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pressed_q    <= ~in_data.raw_port & enabled;
			now_q        <= in_data.now_ms;
			host_ready_q <= in_data.host_ready;
			suspended_q  <= in_data.bus_suspended;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			stable_q        <= '0;
			keys_reported_q <= 1'b0;
			changed_q       <= 1'b0;
			pin_q           <= '0;
			n_q             <= '0;
			kind_q          <= KIND_KEYS;
			for (int i = 0; i < SLOTS; i++) slot_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CMP;
				end
				ST_CMP: begin
					pin_q <= '0;
					if (stable_q == pressed_q) begin
						changed_q <= (stable_q != '0);
						state_q   <= ST_DECIDE;
					end else begin
						changed_q <= 1'b1;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if ((enabled & pin_bit) != '0 &&
							((stable_q ^ pressed_q) & pin_bit) != '0 && expired)
						stable_q <= stable_q ^ pin_bit;
					pin_q <= pin_q + PW'(1);
					if (pin_q == LAST_PIN) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					n_q   <= '0;
					pin_q <= '0;
					for (int i = 0; i < SLOTS; i++) slot_q[i] <= '0;
					if (suspended_q && changed_q) begin
						kind_q  <= KIND_WAKEUP;
						state_q <= ST_FINISH;
					end else if (!host_ready_q) begin
						state_q <= ST_IDLE;
					end else if (changed_q) begin
						kind_q  <= KIND_KEYS;
						state_q <= ST_PACK;
					end else if (keys_reported_q) begin
						keys_reported_q <= 1'b0;
						kind_q          <= KIND_RELEASE;
						state_q         <= ST_FINISH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PACK: begin
					if ((stable_q & pin_bit) != '0 && n_q < KEY_LIMIT) begin
						slot_q[n_q] <= keycode;
						n_q         <= n_q + CNT_W'(1);
					end
					pin_q <= pin_q + PW'(1);
					if (pin_q == LAST_PIN) begin
						keys_reported_q <= 1'b1;
						state_q         <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_q.result_kind <= kind_q;
			out_q.key_slot0   <= slot_q[0];
			out_q.key_slot1   <= slot_q[1];
			out_q.key_slot2   <= slot_q[2];
			out_q.key_slot3   <= slot_q[3];
			out_q.key_slot4   <= slot_q[4];
			out_q.key_slot5   <= slot_q[5];
			out_q.key_count   <= n_q;
		end
	end

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.result_kind == KIND_KEYS ||
			out_data.result_kind == KIND_RELEASE ||
			out_data.result_kind == KIND_WAKEUP))
		else $error("illegal result kind");

	a_empty_nonkey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind != KIND_KEYS |-> out_data.key_count == '0)
		else $error("release or wakeup carries keys");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.key_count <= KEY_LIMIT)
		else $error("key count above limit");

	a_stable_space: assert property (@(posedge clk) disable iff (!arst_n)
		(stable_q & ~PIN_SPACE) == '0)
		else $error("debounced bit outside pin space");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("poll accepted while busy");

endmodule
